// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the decompressor RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== rtl/dnd_pkg.sv =====
// Package for the DNS name decompressor: sizes, codes, state and result types.
// Depends on nothing; imported by dnd_alu, dnd_walker and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dnd_pkg;

    localparam int PACKET_BYTES   = 512;
    localparam int MAX_HOPS       = 16;
    localparam int MAX_NAME_CHARS = 255;

    localparam int CHAR_W   = 8;
    localparam int CHUNK    = 4;
    localparam int CNT_W    = 3;
    localparam int IDX_W    = 2;
    localparam int NEXT_W   = 10;
    localparam int STAT_W   = 3;
    localparam int OFFS_W   = 9;
    localparam int PTR_W    = 14;
    localparam int LLEN_W   = 6;

    localparam int ADDR_W = $clog2(PACKET_BYTES);
    localparam int LEN_W  = $clog2(PACKET_BYTES + 1);
    localparam int POS_W  = (LEN_W > PTR_W) ? LEN_W : PTR_W;
    localparam int ALU_W  = POS_W + 1;
    localparam int HOP_W  = $clog2(MAX_HOPS + 1);
    localparam int NAME_W = $clog2(MAX_NAME_CHARS + 1);

    localparam logic [CHAR_W-1:0] TYPE_MASK   = 8'hC0;
    localparam logic [CHAR_W-1:0] PTR_HI_MASK = 8'h3F;
    localparam logic [CHAR_W-1:0] RSV_HI_BIT  = 8'h80;
    localparam logic [CHAR_W-1:0] RSV_LO_BIT  = 8'h40;
    localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_RESERVED = 3'd1,
        STAT_PAST_END = 3'd2,
        STAT_LOOP     = 3'd3,
        STAT_TOO_LONG = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS_CHK,
        ST_LABEL,
        ST_PTR_CHK,
        ST_PTR_RD,
        ST_LEN_CHK,
        ST_DOT,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FINISH
    } walk_state_t;

    typedef struct packed {
        logic [CHUNK-1:0][CHAR_W-1:0] chars;
        logic [CNT_W-1:0]             count;
        logic                         last;
        logic [NEXT_W-1:0]            next_offset;
        status_t                      status;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/dnd_pkt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; holds the packet bytes for the decompressor.
`timescale 1ns / 1ps
`default_nettype none

module dnd_pkt_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dnd_alu.sv =====
// Shared add-and-compare unit of the name walker.
// Depends on dnd_pkg for the datapath width.
`timescale 1ns / 1ps
`default_nettype none

module dnd_alu
    import dnd_pkg::*;
(
    input  wire logic [ALU_W-1:0] op_a,
    input  wire logic [ALU_W-1:0] op_b,
    input  wire logic [ALU_W-1:0] limit,
    output logic      [ALU_W-1:0] sum,
    output logic                  above,
    output logic                  at_or_above
);

    assign sum         = op_a + op_b;
    assign above       = (sum > limit);
    assign at_or_above = (sum >= limit);

endmodule

`default_nettype wire

// ===== rtl/dnd_walker.sv =====
// Sequencer of the name walker: packet loading, label and pointer walk,
// character packing. Depends on dnd_pkg, dnd_alu, dnd_pkt_ram, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dnd_walker
    import dnd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_command,
    input  wire logic              s_first_byte,
    input  wire logic [CHAR_W-1:0] s_byte_value,
    input  wire logic [OFFS_W-1:0] s_start_offset,
    input  wire logic              out_free,
    output logic                   res_load,
    output result_t                res
);

    walk_state_t state_reg, state_next;

    logic [LEN_W-1:0]             len_reg, len_next;
    logic [POS_W-1:0]             rp_reg, rp_next;
    logic [HOP_W-1:0]             hop_reg, hop_next;
    logic [NAME_W-1:0]            nl_reg, nl_next;
    logic                         jumped_reg, jumped_next;
    logic [LEN_W-1:0]             noff_reg, noff_next;
    status_t                      stat_reg, stat_next;
    logic [CHAR_W-1:0]            x_reg, x_next;
    logic [LLEN_W-1:0]            rem_reg, rem_next;
    logic [CHUNK-1:0][CHAR_W-1:0] chunk_reg, chunk_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    logic [ALU_W-1:0] alu_a, alu_b, alu_lim, alu_sum;
    logic             alu_gt, alu_ge;

    logic              accept;
    logic              chunk_full;
    logic              can_push;
    logic              push;
    logic [CHAR_W-1:0] push_char;
    logic              lbl_zero, lbl_ptr, lbl_rsv;
    logic [PTR_W-1:0]  ptr_target;

    dnd_pkt_ram #(
        .DEPTH (PACKET_BYTES),
        .WIDTH (CHAR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_byte_value),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    dnd_alu u_alu (
        .op_a        (alu_a),
        .op_b        (alu_b),
        .limit       (alu_lim),
        .sum         (alu_sum),
        .above       (alu_gt),
        .at_or_above (alu_ge)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign chunk_full = (cnt_reg == CNT_W'(CHUNK));
    assign can_push   = !chunk_full || out_free;
    assign lbl_zero   = (ram_rdata == '0);
    assign lbl_ptr    = ((ram_rdata & TYPE_MASK) == TYPE_MASK);
    assign lbl_rsv    = !lbl_ptr && (((ram_rdata & RSV_HI_BIT) != '0)
                                  || ((ram_rdata & RSV_LO_BIT) != '0));
    assign ptr_target = {x_reg[PTR_W-CHAR_W-1:0] & PTR_HI_MASK[PTR_W-CHAR_W-1:0], ram_rdata};

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_command == CMD_DECODE) begin
                    state_next = ST_POS_CHK;
                end
            end
            ST_POS_CHK: begin
                state_next = alu_ge ? ST_FINISH : ST_LABEL;
            end
            ST_LABEL: begin
                if (lbl_zero || lbl_rsv) begin
                    state_next = ST_FINISH;
                end else if (lbl_ptr) begin
                    state_next = ST_PTR_CHK;
                end else if (alu_gt) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_LEN_CHK;
                end
            end
            ST_PTR_CHK: begin
                state_next = alu_ge ? ST_FINISH : ST_PTR_RD;
            end
            ST_PTR_RD: begin
                state_next = (hop_reg == HOP_W'(MAX_HOPS)) ? ST_FINISH : ST_POS_CHK;
            end
            ST_LEN_CHK: begin
                if (alu_gt) begin
                    state_next = ST_FINISH;
                end else if (nl_reg != '0) begin
                    state_next = ST_DOT;
                end else begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_DOT: begin
                if (can_push) begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_COPY_RD: begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                if (can_push) begin
                    state_next = (rem_reg == LLEN_W'(1)) ? ST_POS_CHK : ST_COPY_RD;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath controls and register updates.
    always_comb begin
        len_next    = len_reg;
        rp_next     = rp_reg;
        hop_next    = hop_reg;
        nl_next     = nl_reg;
        jumped_next = jumped_reg;
        noff_next   = noff_reg;
        stat_next   = stat_reg;
        x_next      = x_reg;
        rem_next    = rem_reg;
        chunk_next  = chunk_reg;
        cnt_next    = cnt_reg;

        ram_we    = 1'b0;
        ram_waddr = len_reg[ADDR_W-1:0];
        ram_re    = 1'b0;
        ram_raddr = rp_reg[ADDR_W-1:0];

        alu_a   = ALU_W'(rp_reg);
        alu_b   = '0;
        alu_lim = ALU_W'(len_reg);

        push      = 1'b0;
        push_char = ram_rdata;

        res_load        = 1'b0;
        res.chars       = chunk_reg;
        res.count       = cnt_reg;
        res.last        = 1'b0;
        res.next_offset = '0;
        res.status      = STAT_OK;

        case (state_reg)
            ST_IDLE: begin
                if (accept && s_command == CMD_APPEND) begin
                    if (s_first_byte) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        len_next  = LEN_W'(1);
                    end else if (len_reg < LEN_W'(PACKET_BYTES)) begin
                        ram_we   = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end
                end else if (accept) begin
                    rp_next     = POS_W'(s_start_offset);
                    hop_next    = '0;
                    nl_next     = '0;
                    jumped_next = 1'b0;
                    noff_next   = '0;
                    stat_next   = STAT_OK;
                    chunk_next  = '0;
                    cnt_next    = '0;
                end
            end
            ST_POS_CHK: begin
                if (alu_ge) begin
                    stat_next = STAT_PAST_END;
                end else begin
                    ram_re = 1'b1;
                end
            end
            ST_LABEL: begin
                // rp + 1 + x: end of label for the bounds check, and the
                // offset after the terminating zero when x is zero.
                x_next = ram_rdata;
                alu_b  = ALU_W'(ram_rdata) + ALU_W'(1);
                if (lbl_zero) begin
                    if (!jumped_reg) begin
                        noff_next = LEN_W'(alu_sum);
                    end
                end else if (lbl_rsv) begin
                    stat_next = STAT_RESERVED;
                end else if (!lbl_ptr && alu_gt) begin
                    stat_next = STAT_PAST_END;
                end
            end
            ST_PTR_CHK: begin
                alu_b     = ALU_W'(1);
                ram_raddr = alu_sum[ADDR_W-1:0];
                if (alu_ge) begin
                    stat_next = STAT_PAST_END;
                end else begin
                    ram_re = 1'b1;
                end
            end
            ST_PTR_RD: begin
                alu_b = ALU_W'(2);
                if (hop_reg == HOP_W'(MAX_HOPS)) begin
                    stat_next = STAT_LOOP;
                end else begin
                    hop_next    = hop_reg + HOP_W'(1);
                    jumped_next = 1'b1;
                    rp_next     = POS_W'(ptr_target);
                    if (!jumped_reg) begin
                        noff_next = LEN_W'(alu_sum);
                    end
                end
            end
            ST_LEN_CHK: begin
                alu_a    = ALU_W'(nl_reg);
                alu_b    = ALU_W'(x_reg) + ALU_W'(nl_reg != '0);
                alu_lim  = ALU_W'(MAX_NAME_CHARS);
                rem_next = x_reg[LLEN_W-1:0];
                if (alu_gt) begin
                    stat_next = STAT_TOO_LONG;
                end
            end
            ST_DOT: begin
                push      = 1'b1;
                push_char = CHAR_DOT;
                if (can_push) begin
                    nl_next = nl_reg + NAME_W'(1);
                end
            end
            ST_COPY_RD: begin
                alu_b     = ALU_W'(1);
                ram_re    = 1'b1;
                ram_raddr = alu_sum[ADDR_W-1:0];
            end
            ST_COPY_WR: begin
                // Step one byte on, two after the last one to land on the
                // next label byte.
                push  = 1'b1;
                alu_b = (rem_reg == LLEN_W'(1)) ? ALU_W'(2) : ALU_W'(1);
                if (can_push) begin
                    nl_next  = nl_reg + NAME_W'(1);
                    rem_next = rem_reg - LLEN_W'(1);
                    rp_next  = POS_W'(alu_sum);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    res_load        = 1'b1;
                    res.last        = 1'b1;
                    res.status      = stat_reg;
                    res.next_offset = (stat_reg == STAT_OK) ? NEXT_W'(noff_reg) : '0;
                    chunk_next      = '0;
                    cnt_next        = '0;
                end
            end
            default: begin
            end
        endcase

        // Character packing: a full chunk leaves as a non-final transfer
        // when the next character arrives.
        if (push && can_push) begin
            if (chunk_full) begin
                res_load      = 1'b1;
                chunk_next    = '0;
                chunk_next[0] = push_char;
                cnt_next      = CNT_W'(1);
            end else begin
                chunk_next[cnt_reg[IDX_W-1:0]] = push_char;
                cnt_next                       = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            len_reg    <= '0;
            rp_reg     <= '0;
            hop_reg    <= '0;
            nl_reg     <= '0;
            jumped_reg <= 1'b0;
            cnt_reg    <= '0;
            stat_reg   <= STAT_OK;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            rp_reg     <= rp_next;
            hop_reg    <= hop_next;
            nl_reg     <= nl_next;
            jumped_reg <= jumped_next;
            cnt_reg    <= cnt_next;
            stat_reg   <= stat_next;
        end
    end

    always_ff @(posedge aclk) begin
        noff_reg  <= noff_next;
        x_reg     <= x_next;
        rem_reg   <= rem_next;
        chunk_reg <= chunk_next;
    end

    `ASSERT_CLK(a_load_into_free, res_load |-> out_free, "result loaded into busy output")
    `ASSERT_CLK(a_chunk_bound, cnt_reg <= CNT_W'(CHUNK), "chunk count exceeds four")
    `ASSERT_CLK(a_hop_bound, hop_reg <= HOP_W'(MAX_HOPS), "hop count past limit")
    `ASSERT_CLK(a_decode_start, (accept && s_command == CMD_DECODE) |=> (state_reg == ST_POS_CHK), "decode did not start walk")

endmodule

`default_nettype wire

// ===== rtl/dns_name_decompressor_unit.sv =====
// Top level of the DNS name decompressor: walker plus output register.
// Depends on dnd_pkg, dnd_walker, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// DNS name decompressor. Load a packet with append transfers (command 0),
// one byte per cycle; first_byte restarts the packet at offset zero, and
// bytes past the store size are dropped. A decode transfer (command 1)
// walks the label/pointer encoding from start_offset and returns the name
// as dotted text, up to four characters per result; the final result
// carries last_part, the offset just past the name in the packet and a
// status (reserved label, past end, pointer loop, name too long). A decode
// holds the input side busy while it walks: a position check and a label
// state per label byte, a length check per ordinary label, a pointer check
// and read per pointer, a read and a write per character, a dot state per
// dot and a finish state to flush the final result, all through one shared
// add-and-compare unit and the single read port of the packet RAM. Results
// wait in an output register; a stalled output also stalls the walk once
// the next four-character group is complete. No clearing pass after reset.
module dns_name_decompressor_unit
    import dnd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_command,
    input  wire logic              s_first_byte,
    input  wire logic [CHAR_W-1:0] s_byte_value,
    input  wire logic [OFFS_W-1:0] s_start_offset,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [CHAR_W-1:0] m_char_one,
    output logic      [CHAR_W-1:0] m_char_two,
    output logic      [CHAR_W-1:0] m_char_three,
    output logic      [CHAR_W-1:0] m_char_four,
    output logic      [CNT_W-1:0]  m_char_count,
    output logic                   m_last_part,
    output logic      [NEXT_W-1:0] m_next_offset,
    output logic      [STAT_W-1:0] m_status
);

    logic    m_valid_reg, m_valid_next;
    result_t out_reg, out_next;
    logic    out_free;
    logic    res_load;
    result_t res;

    // Output register is free when empty or when its transfer completes now.
    assign out_free = !m_valid_reg || m_ready;

    dnd_walker u_walker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_first_byte   (s_first_byte),
        .s_byte_value   (s_byte_value),
        .s_start_offset (s_start_offset),
        .out_free       (out_free),
        .res_load       (res_load),
        .res            (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload holds no reset.
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_char_one    = out_reg.chars[0];
    assign m_char_two    = out_reg.chars[1];
    assign m_char_three  = out_reg.chars[2];
    assign m_char_four   = out_reg.chars[3];
    assign m_char_count  = out_reg.count;
    assign m_last_part   = out_reg.last;
    assign m_next_offset = out_reg.next_offset;
    assign m_status      = out_reg.status;

    `ASSERT_CLK(a_hold_result, (m_valid && !m_ready) |=> (m_valid && $stable(out_reg)), "result changed while stalled")
    `ASSERT_CLK(a_mid_clean, (m_valid && !m_last_part) |-> (m_status == STAT_OK && m_next_offset == '0 && m_char_count == CNT_W'(CHUNK)), "non-final result malformed")
    `ASSERT_CLK(a_count_bound, m_valid |-> (m_char_count <= CNT_W'(CHUNK)), "character count exceeds four")

endmodule

`default_nettype wire
